@@ hw/rtl/dpr_pkg.sv @@
// shared types and constants of the digital pad responder
package dpr_pkg;

  // input channel item
  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  host_byte;
    logic        next_pressed;
    logic [3:0]  table_index;
    logic [15:0] entry_buttons;
    logic [7:0]  entry_hold;
  } in_item_t;

  // result channel item
  typedef struct packed {
    logic        ack_pulse;
    logic [7:0]  reply_byte;
    logic        drive_reply;
    logic [15:0] buttons_now;
  } out_item_t;

  // configuration register contents
  typedef struct packed {
    logic [3:0] seq_count;
    logic [7:0] lockout_polls;
  } dpr_cfg_t;

  // pipeline movement from the handshake logic to the core
  typedef struct packed {
    logic fire;     // input item taken this cycle
    logic advance;  // stage one item moves to the output register
  } dpr_flow_t;

  // item operation codes
  localparam logic [2:0] OP_SEL_FALL   = 3'd0;
  localparam logic [2:0] OP_BYTE_DONE  = 3'd1;
  localparam logic [2:0] OP_SEL_RISE   = 3'd2;
  localparam logic [2:0] OP_WR_STEP    = 3'd3;
  localparam logic [2:0] OP_WR_SEQ     = 3'd4;

  // byte position codes: replies sent so far
  localparam logic [2:0] POS_CMD       = 3'd0;
  localparam logic [2:0] POS_SENT_ID   = 3'd1;
  localparam logic [2:0] POS_SENT_MARK = 3'd2;
  localparam logic [2:0] POS_SENT_LO   = 3'd3;
  localparam logic [2:0] POS_SENT_HI   = 3'd4;
  localparam logic [2:0] POS_IDLE      = 3'd7;

  // bus bytes
  localparam logic [7:0]  CMD_POLL     = 8'h01;
  localparam logic [7:0]  REPLY_ID     = 8'h41;
  localparam logic [7:0]  REPLY_MARK   = 8'h5A;
  localparam logic [7:0]  REPLY_NONE   = 8'hFF;
  localparam logic [15:0] BUTTONS_IDLE = 16'hFFFF;

  // step entry layout: buttons over hold
  localparam int ENTRY_W = 24;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT   = 2'd1;
  localparam logic [3:0] SEQ_COUNT_RST = 4'd4;
  localparam logic [7:0] LOCKOUT_RST   = 8'd10;

endpackage

@@ hw/rtl/dpr_ram.sv @@
// generic single write, single read ram with registered write-first read
module dpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, a same-cycle write is passed through
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata_r <= wdata;
      end else begin
        rdata_r <= mem[raddr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/dpr_core.sv @@
// exchange tracking, sequence selection and step player of the pad responder
module dpr_core #(
  parameter int STEP_DEPTH = 16,
  parameter int SEQ_DEPTH  = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dpr_pkg::dpr_flow_t            flow,
  input  dpr_pkg::in_item_t             in_data,
  input  dpr_pkg::dpr_cfg_t             cfg_cur,
  input  dpr_pkg::dpr_cfg_t             cfg_nxt,
  output logic                          seq_we,
  output logic [(SEQ_DEPTH > 1 ? $clog2(SEQ_DEPTH) : 1)-1:0] seq_waddr,
  output logic [$clog2(STEP_DEPTH)-1:0] seq_wdata,
  output logic [(SEQ_DEPTH > 1 ? $clog2(SEQ_DEPTH) : 1)-1:0] seq_raddr,
  input  logic [$clog2(STEP_DEPTH)-1:0] seq_rdata,
  output logic                          step_we,
  output logic [$clog2(STEP_DEPTH)-1:0] step_waddr,
  output logic [dpr_pkg::ENTRY_W-1:0]   step_wdata,
  output logic                          step_re,
  output logic [$clog2(STEP_DEPTH)-1:0] step_raddr,
  input  logic [dpr_pkg::ENTRY_W-1:0]   step_rdata,
  output dpr_pkg::out_item_t            out_data
);

  localparam int SW = $clog2(STEP_DEPTH);
  localparam int QW = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
  localparam int CW = $clog2(SEQ_DEPTH + 1);

  // step index wrap table for narrow values
  logic [SW-1:0] mod_tab [256];
  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign mod_tab[g] = SW'(g % STEP_DEPTH);
  end

  // sequence count clamped to 1..SEQ_DEPTH
  function automatic logic [CW-1:0] eff_count(input logic [3:0] cfg);
    logic [CW-1:0] r;
    if (cfg == 4'd0) begin
      r = CW'(1);
    end else if (8'(cfg) > 8'(SEQ_DEPTH)) begin
      r = CW'(SEQ_DEPTH);
    end else begin
      r = CW'(cfg);
    end
    return r;
  endfunction

  // sequence number folded into the used range
  function automatic logic [QW-1:0] seq_index(input logic [QW-1:0] ns,
                                              input logic [CW-1:0] cnt);
    logic [QW-1:0] r;
    if (8'(ns) >= 8'(cnt)) begin
      r = '0;
    end else begin
      r = ns;
    end
    return r;
  endfunction

  // exchange and selection state
  logic [2:0]    pos_r, pos_nxt;
  logic          active_r, active_nxt;
  logic [QW-1:0] ns_r, ns_nxt;
  logic          was_down_r, was_down_nxt;
  logic [7:0]    lock_r, lock_nxt;
  // player state
  logic [SW-1:0] pp_r, pp_nxt;
  logic          playing_r, playing_nxt;
  logic [7:0]    hold_r, hold_nxt;
  logic [15:0]   button_r, button_nxt;
  // stage one payload
  logic          s1_ack_r, s1_ack_nxt;
  logic [7:0]    s1_reply_r, s1_reply_nxt;
  logic          s1_drive_r, s1_drive_nxt;
  logic          s1_load_r, s1_load_nxt;
  dpr_pkg::out_item_t out_r;

  // stage one work values
  logic          poll_end;
  logic [SW-1:0] pp_s1;
  logic          playing_s1;
  logic [7:0]    hold_dec;
  logic [QW-1:0] cur_idx;
  logic [7:0]    tidx_ext;

  assign cur_idx  = seq_index(ns_r, eff_count(cfg_cur.seq_count));
  assign tidx_ext = 8'(in_data.table_index);

  // exchange decoding and poll end selection
  always_comb begin
    pos_nxt      = pos_r;
    active_nxt   = active_r;
    ns_nxt       = ns_r;
    was_down_nxt = was_down_r;
    lock_nxt     = lock_r;
    s1_ack_nxt   = 1'b0;
    s1_reply_nxt = dpr_pkg::REPLY_NONE;
    poll_end     = 1'b0;
    pp_s1        = pp_r;
    playing_s1   = playing_r;
    if (flow.fire) begin
      unique case (in_data.op)
        dpr_pkg::OP_SEL_FALL: begin
          pos_nxt    = dpr_pkg::POS_CMD;
          active_nxt = 1'b0;
        end
        dpr_pkg::OP_BYTE_DONE: begin
          unique case (pos_r)
            dpr_pkg::POS_CMD: begin
              if (in_data.host_byte == dpr_pkg::CMD_POLL) begin
                active_nxt   = 1'b1;
                s1_ack_nxt   = 1'b1;
                s1_reply_nxt = dpr_pkg::REPLY_ID;
                pos_nxt      = dpr_pkg::POS_SENT_ID;
              end else begin
                active_nxt = 1'b0;
                pos_nxt    = dpr_pkg::POS_IDLE;
              end
            end
            dpr_pkg::POS_SENT_ID: begin
              s1_ack_nxt   = 1'b1;
              s1_reply_nxt = dpr_pkg::REPLY_MARK;
              pos_nxt      = dpr_pkg::POS_SENT_MARK;
            end
            dpr_pkg::POS_SENT_MARK: begin
              s1_ack_nxt   = 1'b1;
              s1_reply_nxt = button_r[7:0];
              pos_nxt      = dpr_pkg::POS_SENT_LO;
            end
            dpr_pkg::POS_SENT_LO: begin
              s1_ack_nxt   = 1'b1;
              s1_reply_nxt = button_r[15:8];
              pos_nxt      = dpr_pkg::POS_SENT_HI;
            end
            dpr_pkg::POS_SENT_HI: begin
              poll_end     = 1'b1;
              active_nxt   = 1'b0;
              pos_nxt      = dpr_pkg::POS_IDLE;
              was_down_nxt = in_data.next_pressed;
              if (!was_down_r) begin
                if ((lock_r == 8'd0) && in_data.next_pressed) begin
                  // rising press outside lockout starts the next sequence
                  pp_s1      = seq_rdata;
                  playing_s1 = 1'b1;
                  if (8'(cur_idx) + 8'd1 >= 8'(eff_count(cfg_cur.seq_count))) begin
                    ns_nxt = '0;
                  end else begin
                    ns_nxt = cur_idx + QW'(1);
                  end
                  lock_nxt = cfg_cur.lockout_polls;
                end else if (lock_r != 8'd0) begin
                  lock_nxt = lock_r - 8'd1;
                end
              end else if (in_data.next_pressed) begin
                lock_nxt = cfg_cur.lockout_polls;
              end
            end
            default: begin
            end
          endcase
        end
        dpr_pkg::OP_SEL_RISE: begin
          active_nxt = 1'b0;
          pos_nxt    = dpr_pkg::POS_IDLE;
        end
        default: begin
        end
      endcase
    end
  end

  // hold countdown and step fetch decision
  assign hold_dec     = (hold_r != 8'd0) ? hold_r - 8'd1 : 8'd0;
  assign s1_load_nxt  = poll_end && (hold_dec == 8'd0) && playing_s1;
  assign s1_drive_nxt = active_nxt;

  // player registers: a fetched step lands when its poll end item moves to the output register
  always_comb begin
    pp_nxt      = pp_r;
    playing_nxt = playing_r;
    hold_nxt    = hold_r;
    button_nxt  = button_r;
    if (flow.advance && s1_load_r) begin
      button_nxt = step_rdata[23:8];
      hold_nxt   = step_rdata[7:0];
      pp_nxt     = (pp_r == SW'(STEP_DEPTH - 1)) ? '0 : pp_r + SW'(1);
      if (step_rdata[7:0] == 8'd0) begin
        playing_nxt = 1'b0;
      end
    end else if (poll_end) begin
      pp_nxt      = pp_s1;
      playing_nxt = playing_s1;
      hold_nxt    = hold_dec;
    end
  end

  // table writes and reads
  assign step_we    = flow.fire && (in_data.op == dpr_pkg::OP_WR_STEP);
  assign step_waddr = mod_tab[tidx_ext];
  assign step_wdata = {in_data.entry_buttons, in_data.entry_hold};
  assign step_re    = s1_load_nxt;
  assign step_raddr = pp_s1;
  assign seq_we     = flow.fire && (in_data.op == dpr_pkg::OP_WR_SEQ)
                      && (tidx_ext < 8'(SEQ_DEPTH));
  assign seq_waddr  = tidx_ext[QW-1:0];
  assign seq_wdata  = mod_tab[in_data.entry_hold];
  assign seq_raddr  = seq_index(ns_nxt, eff_count(cfg_nxt.seq_count));

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= dpr_pkg::POS_CMD;
      active_r   <= 1'b0;
      ns_r       <= '0;
      was_down_r <= 1'b0;
      lock_r     <= 8'd0;
      pp_r       <= '0;
      playing_r  <= 1'b0;
      hold_r     <= 8'd0;
      button_r   <= dpr_pkg::BUTTONS_IDLE;
    end else begin
      pos_r      <= pos_nxt;
      active_r   <= active_nxt;
      ns_r       <= ns_nxt;
      was_down_r <= was_down_nxt;
      lock_r     <= lock_nxt;
      pp_r       <= pp_nxt;
      playing_r  <= playing_nxt;
      hold_r     <= hold_nxt;
      button_r   <= button_nxt;
    end
  end

  // stage one payload
  always_ff @(posedge clk) begin
    if (flow.fire) begin
      s1_ack_r   <= s1_ack_nxt;
      s1_reply_r <= s1_reply_nxt;
      s1_drive_r <= s1_drive_nxt;
      s1_load_r  <= s1_load_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (flow.advance) begin
      out_r.ack_pulse   <= s1_ack_r;
      out_r.reply_byte  <= s1_reply_r;
      out_r.drive_reply <= s1_drive_r;
      out_r.buttons_now <= s1_load_r ? step_rdata[23:8] : button_r;
    end
  end

  assign out_data = out_r;

endmodule

@@ hw/rtl/digital_pad_responder_with_macro_player.sv @@
// top level of the digital pad responder with stored button sequence player
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_stall   | in_data  (dpr_pkg::in_item_t)
//   out_    | output    | out_valid / out_stall | out_data (dpr_pkg::out_item_t)
//   cfg_    | input     | cfg_we                | cfg_index, cfg_data
//
// one item per cycle while in_stall is low; a taken item passes the decode stage,
// then the output register, where its result becomes valid (the output register
// also takes the registered step table read)
// synchronous active-low reset clears control state; tables are not cleared
// in_stall rises only while both the decode stage and output register are full
// and out_stall holds the output
module digital_pad_responder_with_macro_player #(
  parameter int STEP_DEPTH = 16,
  parameter int SEQ_DEPTH  = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  dpr_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output dpr_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [dpr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dpr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SW = $clog2(STEP_DEPTH);
  localparam int QW = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;

  dpr_pkg::dpr_cfg_t  cfg_r, cfg_nxt;
  dpr_pkg::dpr_flow_t flow;
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic move;

  logic                        seq_we;
  logic [QW-1:0]               seq_waddr, seq_raddr;
  logic [SW-1:0]               seq_wdata, seq_rdata;
  logic                        step_we, step_re;
  logic [SW-1:0]               step_waddr, step_raddr;
  logic [dpr_pkg::ENTRY_W-1:0] step_wdata, step_rdata;

  // configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        dpr_pkg::REG_SEQ_COUNT: cfg_nxt.seq_count     = cfg_data[3:0];
        dpr_pkg::REG_LOCKOUT:   cfg_nxt.lockout_polls = cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // two-stage handshake
  assign move         = !out_valid_r || !out_stall;
  assign in_stall     = s1_valid_r && !move;
  assign flow.fire    = in_valid && !in_stall;
  assign flow.advance = s1_valid_r && move;
  assign s1_valid_nxt = flow.fire || (s1_valid_r && !move);
  assign out_valid_nxt = move ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seq_count     <= dpr_pkg::SEQ_COUNT_RST;
      cfg_r.lockout_polls <= dpr_pkg::LOCKOUT_RST;
      s1_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // sequence start table
  dpr_ram #(
    .WIDTH (SW),
    .DEPTH (SEQ_DEPTH)
  ) u_seq_ram (
    .clk   (clk),
    .we    (seq_we),
    .waddr (seq_waddr),
    .wdata (seq_wdata),
    .re    (1'b1),
    .raddr (seq_raddr),
    .rdata (seq_rdata)
  );

  // step table
  dpr_ram #(
    .WIDTH (dpr_pkg::ENTRY_W),
    .DEPTH (STEP_DEPTH)
  ) u_step_ram (
    .clk   (clk),
    .we    (step_we),
    .waddr (step_waddr),
    .wdata (step_wdata),
    .re    (step_re),
    .raddr (step_raddr),
    .rdata (step_rdata)
  );

  // exchange and player logic
  dpr_core #(
    .STEP_DEPTH (STEP_DEPTH),
    .SEQ_DEPTH  (SEQ_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .flow       (flow),
    .in_data    (in_data),
    .cfg_cur    (cfg_r),
    .cfg_nxt    (cfg_nxt),
    .seq_we     (seq_we),
    .seq_waddr  (seq_waddr),
    .seq_wdata  (seq_wdata),
    .seq_raddr  (seq_raddr),
    .seq_rdata  (seq_rdata),
    .step_we    (step_we),
    .step_waddr (step_waddr),
    .step_wdata (step_wdata),
    .step_re    (step_re),
    .step_raddr (step_raddr),
    .step_rdata (step_rdata),
    .out_data   (out_data)
  );

endmodule

@@ hw/rtl/dpr_checker.sv @@
// port-level checks of the pad responder and their bind
module dpr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input dpr_pkg::out_item_t out_data
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // acknowledge only comes with a driven reply line
  a_ack_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.ack_pulse |-> out_data.drive_reply)
    else $error("ack without driven reply line");

  // released line carries the idle reply byte
  a_release_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.drive_reply |-> out_data.reply_byte == dpr_pkg::REPLY_NONE)
    else $error("released line with a reply byte");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back pressure");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind digital_pad_responder_with_macro_player dpr_checker u_dpr_checker (.*);

@@ sim/dpr_reply_board_pkg.sv @@
// reply predictor and checker for the pad responder testbench
`timescale 1ns / 100ps

package dpr_reply_board_pkg;
  import dpr_pkg::*;

  localparam int STEPS = 16;
  localparam int SEQS  = 8;

  // op codes with no function in the block
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  class pad_reply_board;
    logic [23:0] steps [STEPS];
    logic [3:0]  seq_starts [SEQS];
    logic [2:0]  byte_pos;
    logic        poll_on;
    logic [15:0] buttons;
    logic [2:0]  next_seq;
    logic [3:0]  play_ptr;
    logic        playing;
    logic [7:0]  hold_left;
    logic        was_down;
    logic [7:0]  lock_left;
    logic [3:0]  seq_count;
    logic [7:0]  lock_polls;
    out_item_t   replies_due [$];
    int          errors;
    int          polls_done;
    int          starts_done;
    int          replies_seen;

    function new();
      foreach (steps[i]) steps[i] = '0;
      foreach (seq_starts[i]) seq_starts[i] = '0;
      byte_pos    = POS_CMD;
      poll_on     = 1'b0;
      buttons     = BUTTONS_IDLE;
      next_seq    = '0;
      play_ptr    = '0;
      playing     = 1'b0;
      hold_left   = '0;
      was_down    = 1'b0;
      lock_left   = '0;
      seq_count   = SEQ_COUNT_RST;
      lock_polls  = LOCKOUT_RST;
      errors      = 0;
      polls_done  = 0;
      starts_done = 0;
      replies_seen = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_SEQ_COUNT) begin
        seq_count = val[3:0];
      end else if (idx == REG_LOCKOUT) begin
        lock_polls = val;
      end
    endfunction

    // next-button edge detect, lockout and step player at the end of a poll
    function void finish_poll(logic pressed);
      int unsigned cnt;
      int unsigned idx;
      logic [23:0] entry;
      polls_done++;
      if (!was_down) begin
        was_down = pressed;
        if (lock_left == 0 && pressed) begin
          cnt = seq_count;
          if (cnt == 0) cnt = 1;
          if (cnt > SEQS) cnt = SEQS;
          idx = next_seq;
          if (idx >= cnt) idx = 0;
          play_ptr = seq_starts[idx];
          playing = 1'b1;
          idx++;
          if (idx >= cnt) idx = 0;
          next_seq = 3'(idx);
          lock_left = lock_polls;
          starts_done++;
        end else if (lock_left > 0) begin
          lock_left--;
        end
      end else begin
        was_down = pressed;
        if (pressed) lock_left = lock_polls;
      end

      if (hold_left > 0) hold_left--;
      if (hold_left == 0 && playing) begin
        entry = steps[play_ptr];
        buttons = entry[23:8];
        hold_left = entry[7:0];
        play_ptr = play_ptr + 4'd1;
        if (hold_left == 0) playing = 1'b0;
      end
    endfunction

    // note one accepted input item and queue the reply it causes
    function void take_item(in_item_t it);
      out_item_t due;
      due.ack_pulse  = 1'b0;
      due.reply_byte = REPLY_NONE;
      case (it.op)
        OP_SEL_FALL: begin
          byte_pos = POS_CMD;
          poll_on = 1'b0;
        end
        OP_BYTE_DONE: begin
          case (byte_pos)
            POS_CMD: begin
              if (it.host_byte == CMD_POLL) begin
                poll_on = 1'b1;
                due.ack_pulse = 1'b1;
                due.reply_byte = REPLY_ID;
                byte_pos = POS_SENT_ID;
              end else begin
                poll_on = 1'b0;
                byte_pos = POS_IDLE;
              end
            end
            POS_SENT_ID: begin
              due.ack_pulse = 1'b1;
              due.reply_byte = REPLY_MARK;
              byte_pos = POS_SENT_MARK;
            end
            POS_SENT_MARK: begin
              due.ack_pulse = 1'b1;
              due.reply_byte = buttons[7:0];
              byte_pos = POS_SENT_LO;
            end
            POS_SENT_LO: begin
              due.ack_pulse = 1'b1;
              due.reply_byte = buttons[15:8];
              byte_pos = POS_SENT_HI;
            end
            POS_SENT_HI: begin
              finish_poll(it.next_pressed);
              poll_on = 1'b0;
              byte_pos = POS_IDLE;
            end
            default: ;
          endcase
        end
        OP_SEL_RISE: begin
          poll_on = 1'b0;
          byte_pos = POS_IDLE;
        end
        OP_WR_STEP: begin
          steps[it.table_index] = {it.entry_buttons, it.entry_hold};
        end
        OP_WR_SEQ: begin
          if (it.table_index < SEQS) seq_starts[it.table_index[2:0]] = it.entry_hold[3:0];
        end
        default: ;
      endcase
      due.drive_reply = poll_on;
      due.buttons_now = buttons;
      replies_due.push_back(due);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // compare one accepted result with the oldest queued reply
    function void check_reply(out_item_t got);
      out_item_t due;
      if (replies_due.size() == 0) begin
        $error("result with no item pending: 0x%0h", got);
        errors++;
        return;
      end
      due = replies_due.pop_front();
      replies_seen++;
      compare_field("ack_pulse", 16'(due.ack_pulse), 16'(got.ack_pulse));
      compare_field("reply_byte", 16'(due.reply_byte), 16'(got.reply_byte));
      compare_field("drive_reply", 16'(due.drive_reply), 16'(got.drive_reply));
      compare_field("buttons_now", due.buttons_now, got.buttons_now);
    endfunction

    function int pending();
      return replies_due.size();
    endfunction
  endclass

endpackage

@@ sim/digital_pad_responder_with_macro_player_test.sv @@
// testbench top of the digital pad responder with macro player
`timescale 1ns / 100ps

module digital_pad_responder_with_macro_player_test;
  import dpr_pkg::*;
  import dpr_reply_board_pkg::*;

  localparam int LONG_HOLD = 60;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int PHASES = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pad_reply_board board = new();
  bit hold_req;
  bit holding;
  bit no_gaps;
  int items_sent;

  // register settings per phase; phase 0 keeps the reset values
  int seq_settings [PHASES] = '{4, 1, 8, 0, 15, 3, 8, 2};
  int lock_settings [PHASES] = '{10, 0, 255, 3, 1, 0, 2, 7};

  digital_pad_responder_with_macro_player u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit: far above the slowest legal run
  initial begin
    #5_000_000;
    $display("FAIL digital_pad_responder_with_macro_player");
    $finish;
  end

  // result sampling
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_reply(out_data);
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int unsigned mode;
    int unsigned len;
    logic        val;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        @(negedge clk) out_stall <= 1'b1;
        holding = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        holding = 1'b0;
      end
      mode = $urandom_range(0, 9);
      if (mode < 3) begin
        val = 1'b0;
        len = $urandom_range(1, 30);
      end else if (mode < 9) begin
        val = 1'($urandom_range(0, 1));
        len = $urandom_range(1, 3);
      end else begin
        val = 1'b1;
        len = $urandom_range(5, 25);
      end
      @(negedge clk) out_stall <= val;
      repeat (len - 1) @(negedge clk);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  // item with every field random except the op
  function automatic in_item_t rand_item(logic [2:0] op);
    in_item_t it;
    it.op            = op;
    it.host_byte     = 8'($urandom);
    it.next_pressed  = 1'($urandom);
    it.table_index   = 4'($urandom);
    it.entry_buttons = 16'($urandom);
    it.entry_hold    = 8'($urandom);
    return it;
  endfunction

  // hold polls of a step: mostly short, some ends, rarely long
  function automatic logic [7:0] step_hold();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'd0;
    if (r < 97) return 8'($urandom_range(1, 3));
    return 8'($urandom);
  endfunction

  // offer one item after a random gap and wait until it is taken
  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_item(it);
    items_sent++;
  endtask

  // one select frame: command, then four bytes, optionally cut short by select rising
  task automatic send_poll(logic [7:0] cmd, int unsigned abort_at, logic pressed);
    in_item_t it;
    send_item(rand_item(OP_SEL_FALL));
    it = rand_item(OP_BYTE_DONE);
    it.host_byte = cmd;
    send_item(it);
    for (int k = 0; k < 4; k++) begin
      if (abort_at == k + 1) begin
        send_item(rand_item(OP_SEL_RISE));
        return;
      end
      it = rand_item(OP_BYTE_DONE);
      if (k == 3) it.next_pressed = pressed;
      send_item(it);
    end
  endtask

  task automatic send_step(logic [3:0] idx, logic [15:0] btn, logic [7:0] hold);
    in_item_t it;
    it = rand_item(OP_WR_STEP);
    it.table_index = idx;
    it.entry_buttons = btn;
    it.entry_hold = hold;
    send_item(it);
  endtask

  task automatic send_seq_start(logic [3:0] idx, logic [7:0] start);
    in_item_t it;
    it = rand_item(OP_WR_SEQ);
    it.table_index = idx;
    it.entry_hold = start;
    send_item(it);
  endtask

  // drop valid and wait until every queued reply has come back
  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk) cfg_we <= 1'b0;
    board.set_register(idx, val);
  endtask

  // random mix: mostly clean polls, some broken frames, table writes and noise
  task automatic run_random(int target);
    int unsigned r;
    logic [7:0]  cmd;
    logic [2:0]  op;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        send_poll(CMD_POLL, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0,
                  1'($urandom_range(0, 1)));
      end else if (r < 75) begin
        cmd = 8'($urandom);
        if (cmd == CMD_POLL) cmd = ~CMD_POLL;
        send_poll(cmd, $urandom_range(0, 4), 1'($urandom_range(0, 1)));
      end else if (r < 87) begin
        if ($urandom_range(0, 2) == 0) begin
          send_item(rand_item(OP_WR_SEQ));
        end else begin
          send_step(4'($urandom), 16'($urandom), step_hold());
        end
      end else begin
        op = 3'($urandom);
        if (op == OP_WR_STEP || op == OP_WR_SEQ) op = OP_SEL_RISE;
        send_item(rand_item(op));
      end
    end
  endtask

  // main sequence
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // fill both tables so no unwritten entry is ever read
    for (int i = 0; i < STEPS; i++) send_step(4'(i), 16'($urandom), step_hold());
    for (int i = 0; i < SEQS; i++) send_seq_start(4'(i), 8'($urandom));

    // directed: full poll with a press, wrong command, early select rise
    send_poll(CMD_POLL, 0, 1'b1);
    send_poll(8'hFF, 3, 1'b0);
    send_poll(CMD_POLL, 2, 1'b1);
    // field extremes, out of range sequence index, unused ops
    send_step(4'hF, 16'h0000, 8'hFF);
    send_step(4'h0, 16'hFFFF, 8'h00);
    send_seq_start(4'd8, 8'hFF);
    send_seq_start(4'hF, 8'h00);
    for (int o = OP_UNUSED_LO; o <= OP_UNUSED_HI; o++) send_item(rand_item(3'(o)));
    send_step(4'hF, 16'($urandom), 8'd1);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        write_reg(REG_SEQ_COUNT, {4'($urandom), 4'(seq_settings[p])});
        write_reg(REG_LOCKOUT, 8'(lock_settings[p]));
      end
      // long receiver hold-off while items keep coming
      if (p == 3) begin
        hold_req = 1'b1;
        wait (holding);
        no_gaps = 1'b1;
        repeat (4) send_poll(CMD_POLL, 0, 1'($urandom_range(0, 1)));
        no_gaps = 1'b0;
      end
      run_random(items_sent + ITEMS_PER_PHASE);
    end

    drain();
    repeat (10) @(negedge clk);

    $display("run covered %0d items, %0d results checked, %0d register settings",
             items_sent, board.replies_seen, PHASES);
    $display("completed polls %0d, sequences started %0d",
             board.polls_done, board.starts_done);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS digital_pad_responder_with_macro_player");
    end else begin
      $display("FAIL digital_pad_responder_with_macro_player");
    end
    $finish;
  end

endmodule
